// ----- rtl/csq_pkg.sv -----
`default_nettype none

package csq_pkg;

    // Table geometry
    localparam int MAX_COLUMNS = 2048;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CFG_W       = 12;
    localparam int EPOCH_W     = 8;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 64;
    localparam int SQ_W     = 63;

    localparam logic [CFG_W-1:0]   MAX_COLUMNS_CFG = CFG_W'(MAX_COLUMNS);
    localparam logic [CFG_W-1:0]   CFG_RESET       = 12'd2048;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST     = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST      = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_NONE      = '0;

    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]  SQ_MAX    = {SQ_W{1'b1}};
    localparam logic [SQ_W-1:0]  SQ_ROUND  = SQ_W'(32'h0000_8000);

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_MERGE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // One table entry: epoch tag plus both accumulators
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq;
    } t_entry;

    // Request after the multiply stage
    typedef struct packed {
        t_cmd             cmd;
        logic [COL_W-1:0] col;
        logic             in_range;
        logic [SUM_W-1:0] sum_add;
        logic [SQ_W-1:0]  sq_prod;
        logic [SQ_W-1:0]  partial_sq;
    } t_stage2;

    typedef struct packed {
        t_status          status;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } t_result;

    // Epoch and clearing-pass control
    typedef struct packed {
        logic               sweep;
        logic [COL_W-1:0]   sweep_addr;
        logic [EPOCH_W-1:0] epoch;
    } t_sweep_ctl;

endpackage

`default_nettype wire

// ----- rtl/csq_ram.sv -----
`default_nettype none

module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read at the written address returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/csq_epoch.sv -----
`default_nettype none

module csq_epoch
    import csq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_clear,
    output t_sweep_ctl o_ctl
);

    localparam logic [COL_W-1:0] SWEEP_LAST = COL_W'(MAX_COLUMNS - 1);

    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_sweep, n_sweep;
    logic [COL_W-1:0]   r_sweep_addr, n_sweep_addr;

    // Advance the clearing pass; bump the epoch on clear, restart the pass on wrap
    always_comb begin
        n_epoch      = r_epoch;
        n_sweep      = r_sweep;
        n_sweep_addr = r_sweep_addr;
        if (r_sweep) begin
            n_sweep_addr = r_sweep_addr + COL_W'(1);
            if (r_sweep_addr == SWEEP_LAST) begin
                n_sweep = 1'b0;
            end
        end
        if (i_clear) begin
            if (r_epoch == EPOCH_LAST) begin
                n_epoch      = EPOCH_FIRST;
                n_sweep      = 1'b1;
                n_sweep_addr = '0;
            end else begin
                n_epoch = r_epoch + EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch      <= EPOCH_FIRST;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            r_epoch      <= n_epoch;
            r_sweep      <= n_sweep;
            r_sweep_addr <= n_sweep_addr;
        end
    end

    assign o_ctl.sweep      = r_sweep;
    assign o_ctl.sweep_addr = r_sweep_addr;
    assign o_ctl.epoch      = r_epoch;

endmodule

`default_nettype wire

// ----- rtl/csq_update.sv -----
`default_nettype none

module csq_update
    import csq_pkg::*;
(
    input  wire t_stage2             i_req,
    input  wire t_entry              i_entry,
    input  wire logic [EPOCH_W-1:0]  i_epoch,
    input  wire logic                i_fw_hit,
    input  wire logic [SUM_W-1:0]    i_fw_sum,
    input  wire logic [SQ_W-1:0]     i_fw_sq,
    output t_result                  o_result,
    output logic                     o_write
);

    logic [SUM_W-1:0] base_sum;
    logic [SQ_W-1:0]  base_sq;
    logic [SQ_W-1:0]  rounded_sq;
    logic [SQ_W-1:0]  sq_add;
    logic [SUM_W-1:0] sum_raw;
    logic [SQ_W:0]    sq_raw;
    logic             sum_ovf;
    logic [SUM_W-1:0] new_sum;
    logic [SQ_W-1:0]  new_sq;

    // Pick the current entry: last write if it hit, else the table word if its tag is live
    always_comb begin
        if (i_fw_hit) begin
            base_sum = i_fw_sum;
            base_sq  = i_fw_sq;
        end else if (i_entry.tag == i_epoch) begin
            base_sum = i_entry.sum;
            base_sq  = i_entry.sq;
        end else begin
            base_sum = '0;
            base_sq  = '0;
        end
    end

    // Round the Q32.32 square to Q.16, half up
    assign rounded_sq = (i_req.sq_prod + SQ_ROUND) >> 16;
    assign sq_add     = (i_req.cmd == CMD_ACC) ? rounded_sq : i_req.partial_sq;

    // Saturating adds
    assign sum_raw = base_sum + i_req.sum_add;
    assign sum_ovf = (base_sum[SUM_W-1] == i_req.sum_add[SUM_W-1])
                  && (sum_raw[SUM_W-1] != base_sum[SUM_W-1]);
    assign new_sum = sum_ovf ? (base_sum[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;
    assign sq_raw  = {1'b0, base_sq} + {1'b0, sq_add};
    assign new_sq  = sq_raw[SQ_W] ? SQ_MAX : sq_raw[SQ_W-1:0];

    // Form the result and the write enable per command
    always_comb begin
        o_result.status = ST_OK;
        o_result.sum    = '0;
        o_result.sq     = '0;
        o_write         = 1'b0;
        case (i_req.cmd)
            CMD_ACC, CMD_MERGE: begin
                if (i_req.in_range) begin
                    o_result.status = (sum_ovf || sq_raw[SQ_W]) ? ST_SAT : ST_OK;
                    o_result.sum    = new_sum;
                    o_result.sq     = new_sq;
                    o_write         = 1'b1;
                end else begin
                    o_result.status = ST_RANGE;
                end
            end
            CMD_READ: begin
                if (i_req.in_range) begin
                    o_result.sum = base_sum;
                    o_result.sq  = base_sq;
                end else begin
                    o_result.status = ST_RANGE;
                end
            end
            default: begin
                o_result.status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/column_sum_and_square_accumulator_top.sv -----
`default_nettype none

// A request passes the input register, stage 2 and the result register; each of them can stall.
// One request, clears included, is accepted per cycle while results are taken and no clearing pass runs.
// After reset, and on every 255th clear, the table memory is swept once, one
// entry per cycle; no request is accepted or advanced meanwhile.
// Reset: synchronous, active low; it clears the pipeline and sets columns in use to 2048.

module column_sum_and_square_accumulator_top
    import csq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_data,

    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_cmd,
    input  wire logic [COL_W-1:0]    i_column,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    input  wire logic signed [SUM_W-1:0]    i_partial_sum,
    input  wire logic [SQ_W-1:0]     i_partial_square_sum,

    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [1:0]               o_status,
    output logic signed [SUM_W-1:0]  o_column_sum,
    output logic [SQ_W-1:0]          o_column_square_sum
);

    logic [CFG_W-1:0] r_cfg;

    // Stage 1: input register
    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic [COL_W-1:0]    r_s1_col;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [SUM_W-1:0]    r_s1_psum;
    logic [SQ_W-1:0]     r_s1_psq;

    // Stage 2: product and table word
    logic    r_s2_valid;
    t_stage2 r_s2;
    t_stage2 n_s2;
    logic    r_s2_stale;

    // Result register
    logic    r_out_valid;
    t_result r_out;

    // Last table write, for the read that raced it
    logic             r_fw_valid;
    logic [COL_W-1:0] r_fw_col;
    logic [SUM_W-1:0] r_fw_sum;
    logic [SQ_W-1:0]  r_fw_sq;

    logic                adv1, adv2, s2_free;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    product;
    t_sweep_ctl          sweep_ctl;
    t_entry              rd_entry;
    t_entry              rd_live;
    t_entry              wr_entry;
    t_result             upd_result;
    logic                upd_write;
    logic                fw_hit;
    logic                ram_we;
    logic [COL_W-1:0]    ram_waddr;
    logic                clear_done;

    // Handshake; hold both stages while the clearing pass owns the table
    assign adv2        = r_s2_valid && (!r_out_valid || i_ready) && !sweep_ctl.sweep;
    assign s2_free     = !r_s2_valid || adv2;
    assign adv1        = r_s1_valid && s2_free && !sweep_ctl.sweep;
    assign o_ready     = (!r_s1_valid || adv1) && !sweep_ctl.sweep;
    assign o_cfg_ready = 1'b1;

    // Hold the columns register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Capture an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end else if (adv1) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_cmd    <= t_cmd'(i_cmd);
            r_s1_col    <= i_column;
            r_s1_sample <= i_sample_value;
            r_s1_psum   <= i_partial_sum;
            r_s1_psq    <= i_partial_square_sum;
        end
    end

    // Square the sample magnitude; select the sum addend; check the column
    assign mag     = r_s1_sample[SAMPLE_W-1] ? (~r_s1_sample + SAMPLE_W'(1)) : r_s1_sample;
    assign product = {{(SUM_W-SAMPLE_W){1'b0}}, mag} * {{(SUM_W-SAMPLE_W){1'b0}}, mag};

    always_comb begin
        n_s2.cmd        = r_s1_cmd;
        n_s2.col        = r_s1_col;
        n_s2.in_range   = ({1'b0, r_s1_col} < r_cfg) && ({1'b0, r_s1_col} < MAX_COLUMNS_CFG);
        n_s2.sum_add    = (r_s1_cmd == CMD_ACC)
                        ? {{(SUM_W-SAMPLE_W){r_s1_sample[SAMPLE_W-1]}}, r_s1_sample}
                        : r_s1_psum;
        n_s2.sq_prod    = product[SQ_W-1:0];
        n_s2.partial_sq = r_s1_psq;
    end

    // Advance into stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= adv1;
        end
    end

    // Mark a request that read the table in the same cycle as a clear retired
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s2       <= n_s2;
            r_s2_stale <= clear_done;
        end
    end

    // Epoch tags and clearing pass
    assign clear_done = adv2 && (r_s2.cmd == CMD_CLEAR);

    csq_epoch u_epoch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clear_done),
        .o_ctl   (sweep_ctl)
    );

    // Table memory: stage 2 writes back, the pass writes dead tags
    assign ram_we         = sweep_ctl.sweep || (adv2 && upd_write);
    assign ram_waddr      = sweep_ctl.sweep ? sweep_ctl.sweep_addr : r_s2.col;
    assign wr_entry.tag   = sweep_ctl.sweep ? EPOCH_NONE : sweep_ctl.epoch;
    assign wr_entry.sum   = upd_result.sum;
    assign wr_entry.sq    = upd_result.sq;

    csq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_COLUMNS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (adv1),
        .i_raddr (r_s1_col),
        .o_rdata (rd_entry)
    );

    // Drop a table word read before the clear took effect
    assign rd_live.tag = r_s2_stale ? EPOCH_NONE : rd_entry.tag;
    assign rd_live.sum = rd_entry.sum;
    assign rd_live.sq  = rd_entry.sq;

    // Forward the last write; drop it on clear
    assign fw_hit = r_fw_valid && (r_fw_col == r_s2.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (clear_done) begin
            r_fw_valid <= 1'b0;
        end else if (adv2 && upd_write) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && upd_write) begin
            r_fw_col <= r_s2.col;
            r_fw_sum <= upd_result.sum;
            r_fw_sq  <= upd_result.sq;
        end
    end

    csq_update u_update (
        .i_req    (r_s2),
        .i_entry  (rd_live),
        .i_epoch  (sweep_ctl.epoch),
        .i_fw_hit (fw_hit),
        .i_fw_sum (r_fw_sum),
        .i_fw_sq  (r_fw_sq),
        .o_result (upd_result),
        .o_write  (upd_write)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv2) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_out <= upd_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out.status;
    assign o_column_sum        = r_out.sum;
    assign o_column_square_sum = r_out.sq;

endmodule

`default_nettype wire
